>>> hdl/tpns_pkg.sv
// Shared types, codes and constants for the two-priority note sequencer.
// Holds the action codes, queue entry layout, tone table and queue control struct.
// No dependencies.
package tpns_pkg;

    // Action codes carried in s_tuser
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_URGENT = 2'd1;
    localparam logic [1:0] ACT_NORMAL = 2'd2;
    localparam logic [1:0] ACT_FORCE  = 2'd3;

    // Queue entry: duration in the upper bits, table index in the lower bits
    localparam int DUR_W   = 8;
    localparam int IDX_W   = 6;
    localparam int ENTRY_W = DUR_W + IDX_W;
    localparam int HZ_W    = 12;
    localparam int PER_W   = 17;

    localparam logic [DUR_W-1:0] IDLE_LEFT  = 8'hFF;
    localparam logic [PER_W-1:0] TONE_CLOCK = 17'd100000;

    // Queue push/pop strobes
    typedef struct packed {
        logic push;
        logic pop;
    } tpns_qctl_t;

    // Tone table in hertz; entries past the last note are silence
    function automatic logic [HZ_W-1:0] tone_hz(input logic [IDX_W-1:0] idx);
        logic [HZ_W-1:0] hz;
        begin
            case (idx)
                6'd0:  hz = 12'd131;
                6'd1:  hz = 12'd139;
                6'd2:  hz = 12'd147;
                6'd3:  hz = 12'd156;
                6'd4:  hz = 12'd165;
                6'd5:  hz = 12'd175;
                6'd6:  hz = 12'd185;
                6'd7:  hz = 12'd196;
                6'd8:  hz = 12'd208;
                6'd9:  hz = 12'd220;
                6'd10: hz = 12'd233;
                6'd11: hz = 12'd247;
                6'd12: hz = 12'd262;
                6'd13: hz = 12'd277;
                6'd14: hz = 12'd294;
                6'd15: hz = 12'd311;
                6'd16: hz = 12'd330;
                6'd17: hz = 12'd349;
                6'd18: hz = 12'd370;
                6'd19: hz = 12'd392;
                6'd20: hz = 12'd415;
                6'd21: hz = 12'd440;
                6'd22: hz = 12'd466;
                6'd23: hz = 12'd494;
                6'd24: hz = 12'd523;
                6'd25: hz = 12'd554;
                6'd26: hz = 12'd587;
                6'd27: hz = 12'd622;
                6'd28: hz = 12'd659;
                6'd29: hz = 12'd698;
                6'd30: hz = 12'd740;
                6'd31: hz = 12'd784;
                6'd32: hz = 12'd831;
                6'd33: hz = 12'd880;
                6'd34: hz = 12'd932;
                6'd35: hz = 12'd988;
                6'd36: hz = 12'd1046;
                6'd37: hz = 12'd1108;
                6'd38: hz = 12'd1174;
                6'd39: hz = 12'd1244;
                6'd40: hz = 12'd1318;
                6'd41: hz = 12'd1396;
                6'd42: hz = 12'd1479;
                6'd43: hz = 12'd1567;
                6'd44: hz = 12'd1661;
                6'd45: hz = 12'd1760;
                6'd46: hz = 12'd1864;
                6'd47: hz = 12'd1975;
                6'd48: hz = 12'd2093;
                6'd49: hz = 12'd2217;
                6'd50: hz = 12'd2349;
                6'd51: hz = 12'd2489;
                6'd52: hz = 12'd2637;
                6'd53: hz = 12'd2793;
                6'd54: hz = 12'd2959;
                6'd55: hz = 12'd3135;
                6'd56: hz = 12'd3322;
                6'd57: hz = 12'd3520;
                6'd58: hz = 12'd3729;
                6'd59: hz = 12'd3951;
                default: hz = 12'd0;
            endcase
            return hz;
        end
    endfunction

endpackage

>>> hdl/tpns_div.sv
// Iterative restoring divider: fixed tone clock divided by a frequency.
// One quotient bit per cycle. Uses tpns_pkg.
module tpns_div
    import tpns_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      divisor,
    output logic             done,
    output logic [PER_W-1:0] quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [PER_W-1:0] rem_reg;
    logic [PER_W-1:0] quot_reg;
    logic [15:0]      dvs_reg;
    logic [PER_W-1:0] trial;
    logic             fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg[PER_W-2:0], TONE_CLOCK[cnt_reg]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Step the division, MSB first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == 5'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(PER_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    // Hold remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quot_reg <= {quot_reg[PER_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> hdl/tpns_queue.sv
// Note queue: circular buffer in a memory with a registered head read.
// Push writes at the tail, pop advances the head. Uses tpns_pkg.
module tpns_queue
    import tpns_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpns_qctl_t                    ctl,
    input  logic [ENTRY_W-1:0]            wr_data,
    output logic [ENTRY_W-1:0]            head,
    output logic [$clog2(DEPTH+1)-1:0]    fill
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] head_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;

    // Write at the tail, read the head every cycle
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        head_reg <= mem[rd_ptr_reg];
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (ctl.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (ctl.push && !ctl.pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (ctl.pop && !ctl.push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assign head = head_reg;
    assign fill = fill_reg;

endmodule

>>> hdl/two_priority_note_sequencer_core.sv
// Two-priority buzzer note sequencer: an urgent and a normal note queue, a tick
// engine, and timer period/compare output. Every input word gives one result word.
// A tick steps through the fetch, wait, urgent, normal and finish states, then
// divides when it moves to a new nonzero pitch (a tick while the engine is stopped
// goes straight to the result); an enqueue checks and pushes; a force divides unless
// its frequency is zero: pitch changes run 100000/freq through one shared iterative
// divider at one quotient bit per cycle. The block takes one word at a time and is
// ready again the cycle after its result is loaded; a finished result waits in the
// output register while the next word is accepted, and the block holds while an
// earlier result still waits there. Depends on tpns_pkg, tpns_queue and tpns_div.
module two_priority_note_sequencer_core
    import tpns_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int TABLE_SIZE  = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: lowest_note
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // duration[7:0], note[15:8], frequency[31:16]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // period[16:0], compare[32:17], tone_on[33],
                                   // accepted[34], running[35], zero[39:36]
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);
    localparam logic [8:0]        TBL_LIM   = 9'(TABLE_SIZE);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ENQ   = 4'd1;
    localparam logic [3:0] ST_FETCH = 4'd2;
    localparam logic [3:0] ST_WAIT  = 4'd3;
    localparam logic [3:0] ST_URG   = 4'd4;
    localparam logic [3:0] ST_NRM   = 4'd5;
    localparam logic [3:0] ST_FIN   = 4'd6;
    localparam logic [3:0] ST_DRIVE = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]         state_reg;
    logic [7:0]         lowest_reg;
    logic [1:0]         act_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [7:0]         note_reg;
    logic [DUR_W-1:0]   ul_reg;
    logic [DUR_W-1:0]   nl_reg;
    logic [HZ_W-1:0]    resume_reg;
    logic               engine_reg;
    logic [PER_W-1:0]   period_reg;
    logic               acc_reg;
    logic               drv_reg;
    logic [15:0]        drv_hz_reg;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    logic               in_fire;
    logic [8:0]         diff;
    logic               enq_ok;
    logic [DUR_W-1:0]   dur_adj;
    logic [ENTRY_W-1:0] wr_entry;
    tpns_qctl_t         uq_ctl;
    tpns_qctl_t         nq_ctl;
    logic [ENTRY_W-1:0] u_head;
    logic [ENTRY_W-1:0] n_head;
    logic [FILL_W-1:0]  u_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [FILL_W-1:0]  tgt_fill;
    logic               u_due;
    logic               n_due;
    logic               div_start;
    logic               div_done;
    logic [PER_W-1:0]   div_quot;
    logic               out_free;
    logic [HZ_W-1:0]    u_hz;
    logic [HZ_W-1:0]    n_hz;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Enqueue check: room, nonzero duration, note inside the table
    always_comb
    begin
        diff     = {1'b0, note_reg} - {1'b0, lowest_reg};
        tgt_fill = (act_reg == ACT_URGENT) ? u_fill : n_fill;
        enq_ok   = (tgt_fill < FULL_FILL) && (dur_reg != '0) && !diff[8]
                   && (diff < TBL_LIM) && (diff[8:IDX_W] == '0);
        dur_adj  = (dur_reg == IDLE_LEFT) ? IDLE_LEFT - 1'b1 : dur_reg;
        wr_entry = {dur_adj, diff[IDX_W-1:0]};
    end

    // Queue strobes, head tone lookups and divider start
    always_comb
    begin
        u_due       = (ul_reg == '0) || (ul_reg == IDLE_LEFT);
        n_due       = (nl_reg == '0) || (nl_reg == IDLE_LEFT);
        uq_ctl.push = (state_reg == ST_ENQ) && enq_ok && (act_reg == ACT_URGENT);
        nq_ctl.push = (state_reg == ST_ENQ) && enq_ok && (act_reg == ACT_NORMAL);
        uq_ctl.pop  = (state_reg == ST_URG) && u_due && (u_fill != '0);
        nq_ctl.pop  = (state_reg == ST_NRM) && n_due && (n_fill != '0);
        u_hz        = tone_hz(u_head[IDX_W-1:0]);
        n_hz        = tone_hz(n_head[IDX_W-1:0]);
        div_start   = (state_reg == ST_DRIVE) && (drv_hz_reg != '0);
    end

    tpns_queue #(.DEPTH(QUEUE_DEPTH)) u_urgent_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (uq_ctl),
        .wr_data (wr_entry),
        .head    (u_head),
        .fill    (u_fill)
    );

    tpns_queue #(.DEPTH(QUEUE_DEPTH)) u_normal_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (nq_ctl),
        .wr_data (wr_entry),
        .head    (n_head),
        .fill    (n_fill)
    );

    tpns_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (drv_hz_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Capture input word fields
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= s_tuser;
            dur_reg  <= s_tdata[7:0];
            note_reg <= s_tdata[15:8];
        end
    end

    // Sequencer and playback state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lowest_reg   <= '0;
            ul_reg       <= IDLE_LEFT;
            nl_reg       <= IDLE_LEFT;
            resume_reg   <= '0;
            engine_reg   <= 1'b0;
            period_reg   <= '0;
            acc_reg      <= 1'b0;
            drv_reg      <= 1'b0;
            drv_hz_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                lowest_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && !((state_reg == ST_DONE) && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        acc_reg <= 1'b0;
                        drv_reg <= 1'b0;
                        case (s_tuser)
                            ACT_TICK:
                            begin
                                state_reg <= engine_reg ? ST_FETCH : ST_DONE;
                            end
                            ACT_FORCE:
                            begin
                                drv_hz_reg <= s_tdata[31:16];
                                state_reg  <= ST_DRIVE;
                            end
                            default:
                            begin
                                state_reg <= ST_ENQ;
                            end
                        endcase
                    end
                end

                ST_ENQ:
                begin
                    if (enq_ok)
                    begin
                        acc_reg    <= 1'b1;
                        engine_reg <= 1'b1;
                    end
                    state_reg <= ST_DONE;
                end

                // Count down both running notes
                ST_FETCH:
                begin
                    if (ul_reg != IDLE_LEFT)
                    begin
                        ul_reg <= ul_reg - 1'b1;
                    end
                    if (nl_reg != IDLE_LEFT)
                    begin
                        nl_reg <= nl_reg - 1'b1;
                    end
                    state_reg <= ST_WAIT;
                end

                // Let the registered queue heads settle
                ST_WAIT:
                begin
                    state_reg <= ST_URG;
                end

                // Urgent side: fetch the next note or fall back to the saved pitch
                ST_URG:
                begin
                    if (u_due)
                    begin
                        if (u_fill != '0)
                        begin
                            ul_reg     <= u_head[ENTRY_W-1:IDX_W];
                            drv_reg    <= 1'b1;
                            drv_hz_reg <= 16'(u_hz);
                        end
                        else if (ul_reg == '0)
                        begin
                            ul_reg     <= IDLE_LEFT;
                            drv_reg    <= 1'b1;
                            drv_hz_reg <= 16'(resume_reg);
                        end
                    end
                    state_reg <= ST_NRM;
                end

                // Normal side: fetch the next note, save its pitch
                ST_NRM:
                begin
                    if (n_due)
                    begin
                        if (n_fill != '0)
                        begin
                            resume_reg <= n_hz;
                            nl_reg     <= n_head[ENTRY_W-1:IDX_W];
                            if (ul_reg == IDLE_LEFT)
                            begin
                                drv_reg    <= 1'b1;
                                drv_hz_reg <= 16'(n_hz);
                            end
                        end
                        else
                        begin
                            nl_reg     <= IDLE_LEFT;
                            resume_reg <= '0;
                        end
                    end
                    state_reg <= ST_FIN;
                end

                // Stop the engine once everything has drained
                ST_FIN:
                begin
                    if ((u_fill == '0) && (n_fill == '0) &&
                        (ul_reg == IDLE_LEFT) && (nl_reg == IDLE_LEFT))
                    begin
                        period_reg <= '0;
                        engine_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= drv_reg ? ST_DRIVE : ST_DONE;
                    end
                end

                // Zero frequency is silence, otherwise divide
                ST_DRIVE:
                begin
                    if (drv_hz_reg == '0)
                    begin
                        period_reg <= '0;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        period_reg <= div_quot;
                        state_reg  <= ST_DONE;
                    end
                end

                // Hand the result word to the output register
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {4'b0000, engine_reg, acc_reg, (period_reg != '0),
                            period_reg[PER_W-1:1], period_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
